@@ design/ill_pkg.sv @@
// ============================================================================
// ill_pkg: shared types and constants for the interval lane layout block
// Holds the command codes, table sizes and the sequencer state type.
// ============================================================================
package ill_pkg;

  localparam int unsigned MaxIntervals = 1024;
  localparam int unsigned MaxLanes     = 16;
  localparam int unsigned IdxW         = $clog2(MaxIntervals);
  localparam int unsigned CntW         = IdxW + 1;
  localparam int unsigned LaneW        = $clog2(MaxLanes);
  localparam int unsigned LaneCntW     = LaneW + 1;
  localparam logic [7:0]  GreyLevel    = 8'd200;

  typedef enum logic [1:0] {
    CmdLoad    = 2'd0,
    CmdRow     = 2'd1,
    CmdRestart = 2'd2,
    CmdNone    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StAge,
    StSkipRd,
    StSkipChk,
    StPlace,
    StEmit
  } state_e;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] stop;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } ival_t;

endpackage

@@ design/ill_ram.sv @@
// ============================================================================
// ill_ram: interval table store
// One write port and one registered read port.
// ============================================================================
module ill_ram
  import ill_pkg::*;
(
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  ival_t           wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output ival_t           rdata_o
);

  ival_t mem [MaxIntervals];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ design/interval_lane_layout_top.sv @@
// ============================================================================
// interval_lane_layout_top: arranges loaded intervals into display lanes
// A small sequencer walks the lane table one lane per cycle and the interval
// memory one entry at a time, sharing one set of window compares across entries.
// ============================================================================
// channel  | direction | handshake
// config   | in        | cfg_we_i, cfg_idx_i, cfg_data_i
// request  | in        | start while busy low
// result   | out       | valid_o high per lane result, no stall
//
// Load, restart, unused commands and a row with an empty table finish in the
// accepting cycle; busy stays low. Any other row keeps busy high while it ages
// the lanes in use, passes over expired entries, places each overlapping entry,
// finds the end of the run and then gives one result per lane in use. The
// registered interval memory read sets the per-entry cost.
// Reset: empty table, all lanes free, one lane in use, view_start 0.
// Results cannot be held off by the receiver.
module interval_lane_layout_top
  import ill_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [31:0] interval_start_i,
  input  logic [31:0] interval_stop_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  output logic        valid_o,
  output logic [3:0]  lane_index_o,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic        occupied_o,
  output logic        overflow_o,
  output logic        last_lane_o
);

  localparam logic CfgViewStart = 1'b0;
  localparam logic CfgLineWidth = 1'b1;

  state_e state_q, state_d;

  logic [31:0]       view_start_q;
  logic [15:0]       line_width_q;
  logic [CntW-1:0]   icount_q;
  logic [CntW-1:0]   next_q, next_d;
  logic [LaneCntW-1:0] in_use_q, in_use_d;
  logic [31:0]       row_start_q;
  logic [31:0]       line_start_q;
  logic [32:0]       line_stop_q;
  logic [LaneW-1:0]  k_q, k_d;
  logic              ovf_q, ovf_d;
  logic              placing_q;

  logic [MaxLanes-1:0] l_valid_q, l_aged_q;
  logic [31:0]         l_stop_q [MaxLanes];
  logic [23:0]         l_rgb_q  [MaxLanes];

  logic  accept;
  cmd_e  cmd;
  ival_t rd;
  ival_t wr;
  logic  we;

  assign cmd    = cmd_e'(command_i);
  assign accept = start && !busy;
  assign busy   = (state_q != StIdle);

  assign wr = '{start: interval_start_i, stop: interval_stop_i,
                red: red_in_i, green: green_in_i, blue: blue_in_i};
  assign we = accept && cmd == CmdLoad && icount_q < CntW'(MaxIntervals);

  ill_ram u_ram (
    .clk_i,
    .we_i   (we),
    .waddr_i(icount_q[IdxW-1:0]),
    .wdata_i(wr),
    .raddr_i(next_q[IdxW-1:0]),
    .rdata_o(rd)
  );

  // shared compare unit and lane search
  logic              more;
  logic              fits;
  logic              skip_now;
  logic [LaneW-1:0]  free_idx;
  logic              free_hit;
  logic              lane_ok;
  assign more = (next_q < icount_q);
  assign fits = ({1'b0, rd.start} <= line_stop_q) && (rd.stop >= line_start_q);
  // expired entries are passed over only before the first placement
  assign skip_now = !placing_q && (rd.stop < line_start_q);
  assign lane_ok = {1'b0, k_q} < in_use_q;

  always_comb begin
    free_hit = 1'b0;
    free_idx = '0;
    for (int i = 0; i < MaxLanes; i++) begin
      if (!free_hit && LaneCntW'(i) < in_use_q && !l_valid_q[i]) begin
        free_hit = 1'b1;
        free_idx = LaneW'(i);
      end
    end
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    next_d   = next_q;
    in_use_d = in_use_q;
    k_d      = k_q;
    ovf_d    = ovf_q;
    case (state_q)
      StIdle: begin
        if (accept && cmd == CmdRow && icount_q != '0) begin
          state_d = StAge;
          k_d     = '0;
          ovf_d   = 1'b0;
        end
      end
      StAge: begin
        k_d = k_q + 1'b1;
        if (!lane_ok || k_q == LaneW'(MaxLanes - 1)) begin
          state_d = StSkipRd;
        end
      end
      StSkipRd: state_d = more ? StSkipChk : StEmit;
      StSkipChk: begin
        if (skip_now) begin
          next_d  = next_q + 1'b1;
          state_d = StSkipRd;
        end else if (fits) begin
          state_d = StPlace;
        end else begin
          state_d = StEmit;
        end
      end
      StPlace: begin
        next_d = next_q + 1'b1;
        if (!free_hit) begin
          if (in_use_q >= LaneCntW'(MaxLanes)) begin
            ovf_d = 1'b1;
          end else begin
            in_use_d = in_use_q + 1'b1;
          end
        end
        state_d = StSkipRd;
        k_d     = '0;
      end
      StEmit: begin
        k_d = k_q + 1'b1;
        if ({1'b0, k_q} + 1'b1 == in_use_q) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    if (state_q == StSkipRd && !more) begin
      k_d = '0;
    end
    if (state_q == StSkipChk && !skip_now && !fits) begin
      k_d = '0;
    end
    if (state_q == StIdle && accept && cmd == CmdRestart) begin
      in_use_d = LaneCntW'(1);
      next_d   = '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      view_start_q <= '0;
      line_width_q <= 16'd1;
      icount_q     <= '0;
      next_q       <= '0;
      in_use_q     <= LaneCntW'(1);
      row_start_q  <= '0;
      k_q          <= '0;
      ovf_q        <= 1'b0;
      placing_q    <= 1'b0;
      l_valid_q    <= '0;
      l_aged_q     <= '0;
    end else begin
      state_q  <= state_d;
      next_q   <= next_d;
      in_use_q <= in_use_d;
      k_q      <= k_d;
      ovf_q    <= ovf_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgViewStart: view_start_q <= cfg_data_i;
          CfgLineWidth: line_width_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (we) begin
        icount_q <= icount_q + 1'b1;
      end
      if (accept && cmd == CmdRestart) begin
        row_start_q <= view_start_q;
        l_valid_q   <= '0;
        l_aged_q    <= '0;
      end
      if (accept && cmd == CmdRow) begin
        row_start_q <= row_start_q + {16'd0, line_width_q};
        placing_q   <= 1'b0;
      end
      if (state_q == StPlace) begin
        placing_q <= 1'b1;
      end
      if (state_q == StAge && lane_ok && l_valid_q[k_q] &&
          l_stop_q[k_q] < line_start_q) begin
        if (l_aged_q[k_q]) begin
          l_valid_q[k_q] <= 1'b0;
          l_aged_q[k_q]  <= 1'b0;
        end else begin
          l_aged_q[k_q]  <= 1'b1;
        end
      end
      if (state_q == StPlace && (free_hit || in_use_q < LaneCntW'(MaxLanes))) begin
        l_valid_q[free_hit ? free_idx : in_use_q[LaneW-1:0]] <= 1'b1;
        l_aged_q[free_hit ? free_idx : in_use_q[LaneW-1:0]]  <= 1'b0;
      end
    end
  end

  // row window and lane payload
  always_ff @(posedge clk_i) begin
    if (accept && cmd == CmdRow) begin
      line_start_q <= row_start_q;
      line_stop_q  <= {1'b0, row_start_q} + {17'd0, line_width_q};
    end
    if (state_q == StPlace && (free_hit || in_use_q < LaneCntW'(MaxLanes))) begin
      l_stop_q[free_hit ? free_idx : in_use_q[LaneW-1:0]] <= rd.stop;
      l_rgb_q[free_hit ? free_idx : in_use_q[LaneW-1:0]]  <=
        {rd.red, rd.green, rd.blue};
    end
  end

  // result drive
  logic shown;
  assign shown        = l_valid_q[k_q] && !l_aged_q[k_q];
  assign valid_o      = (state_q == StEmit);
  assign lane_index_o = 4'(k_q);
  assign red_out_o    = shown ? l_rgb_q[k_q][23:16] : GreyLevel;
  assign green_out_o  = shown ? l_rgb_q[k_q][15:8]  : GreyLevel;
  assign blue_out_o   = shown ? l_rgb_q[k_q][7:0]   : GreyLevel;
  assign occupied_o   = l_valid_q[k_q];
  assign overflow_o   = ovf_q;
  assign last_lane_o  = ({1'b0, k_q} + 1'b1 == in_use_q);

  // checks
  a_lanes_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_use_q != '0 && in_use_q <= LaneCntW'(MaxLanes))
    else $error("lanes in use out of range");
  a_next_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_q <= icount_q)
    else $error("next entry beyond count");
  a_emit_lane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> {1'b0, k_q} < in_use_q)
    else $error("result for lane not in use");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_lane_o |=> state_q == StIdle)
    else $error("row did not end after last lane");

endmodule

@@ tb/interval_lane_layout_checker.sv @@
// ============================================================================
// interval_lane_layout_checker: lane layout predictor and result comparator
// Watches the config, request and result channels of the layout block, keeps
// its own copy of the interval table and lane state, queues the lane colours
// each row should produce and compares every result strobe against them.
// ============================================================================
module interval_lane_layout_checker
  import ill_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  command_i,
  input  logic [31:0] interval_start_i,
  input  logic [31:0] interval_stop_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  input  logic        valid_o,
  input  logic [3:0]  lane_index_o,
  input  logic [7:0]  red_out_o,
  input  logic [7:0]  green_out_o,
  input  logic [7:0]  blue_out_o,
  input  logic        occupied_o,
  input  logic        overflow_o,
  input  logic        last_lane_o,
  output int          fail_count_o,
  output int          pending_o
);

  localparam logic CfgViewStart = 1'b0;
  localparam logic CfgLineWidth = 1'b1;

  typedef struct packed {
    logic        valid;
    logic        aged;
    logic [31:0] stop;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } lane_slot_t;

  typedef struct packed {
    logic [3:0] lane;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       occupied;
    logic       overflow;
    logic       last;
  } lane_colour_t;

  // shadow layout state
  ival_t        intervals [MaxIntervals];
  lane_slot_t   lanes [MaxLanes];
  int unsigned  loaded;
  int unsigned  head;
  int unsigned  lane_count;
  logic [31:0]  row_pos;
  logic [31:0]  view_start;
  logic [15:0]  line_width;
  lane_colour_t lane_colours_q[$];

  task automatic restart_lanes();
    for (int k = 0; k < MaxLanes; k++) lanes[k] = '0;
    lane_count = 1;
    head       = 0;
    row_pos    = view_start;
  endtask

  // first free lane, else append; returns 0 when the interval is dropped
  function automatic bit seat_interval(ival_t iv);
    int slot;
    slot = -1;
    for (int k = 0; k < lane_count && k < MaxLanes; k++) begin
      if (!lanes[k].valid) begin
        slot = k;
        break;
      end
    end
    if (slot < 0) begin
      if (lane_count >= MaxLanes) return 0;
      slot = lane_count;
      lane_count++;
    end
    lanes[slot] = '{1'b1, 1'b0, iv.stop, iv.red, iv.green, iv.blue};
    return 1;
  endfunction

  task automatic lay_out_row();
    logic [31:0]  row_lo;
    logic [32:0]  row_hi;
    bit           dropped;
    int unsigned  n;
    lane_colour_t c;
    row_lo  = row_pos;
    row_hi  = {1'b0, row_pos} + {17'd0, line_width};
    row_pos = row_pos + {16'd0, line_width};
    dropped = 0;
    if (loaded == 0) return;
    // ageing: one grey row, then free
    for (int k = 0; k < lane_count && k < MaxLanes; k++) begin
      if (lanes[k].valid && lanes[k].stop < row_lo) begin
        if (lanes[k].aged) begin
          lanes[k].valid = 0;
          lanes[k].aged  = 0;
        end else begin
          lanes[k].aged = 1;
        end
      end
    end
    // pass over expired entries at the head
    while (head < loaded && intervals[head].stop < row_lo) head++;
    // seat overlapping entries
    while (head < loaded) begin
      if (!({1'b0, intervals[head].start} <= row_hi && intervals[head].stop >= row_lo))
        break;
      if (!seat_interval(intervals[head])) dropped = 1;
      head++;
    end
    n = (lane_count > MaxLanes) ? MaxLanes : lane_count;
    for (int k = 0; k < n; k++) begin
      c.lane = k[3:0];
      if (lanes[k].valid && !lanes[k].aged) begin
        c.red   = lanes[k].red;
        c.green = lanes[k].green;
        c.blue  = lanes[k].blue;
      end else begin
        c.red   = GreyLevel;
        c.green = GreyLevel;
        c.blue  = GreyLevel;
      end
      c.occupied = lanes[k].valid;
      c.overflow = dropped;
      c.last     = (k + 1 == n);
      lane_colours_q = {lane_colours_q, c};
    end
  endtask

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lane_colour_t e;
    if (!rst_ni) begin
      view_start   = '0;
      line_width   = 16'd1;
      loaded       = 0;
      fail_count_o = 0;
      lane_colours_q.delete();
      restart_lanes();
    end else begin
      // results first: they stem from earlier requests
      if (valid_o) begin
        if (lane_colours_q.size() == 0) begin
          $error("unexpected lane result for lane %0d", lane_index_o);
          fail_count_o++;
        end else begin
          e = lane_colours_q.pop_front();
          compare_field("lane_index", e.lane, lane_index_o);
          compare_field("red_out", e.red, red_out_o);
          compare_field("green_out", e.green, green_out_o);
          compare_field("blue_out", e.blue, blue_out_o);
          compare_field("occupied", e.occupied, occupied_o);
          compare_field("overflow", e.overflow, overflow_o);
          compare_field("last_lane", e.last, last_lane_o);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgViewStart) view_start = cfg_data_i;
        else if (cfg_idx_i == CfgLineWidth) line_width = cfg_data_i[15:0];
      end
      if (start && !busy) begin
        case (cmd_e'(command_i))
          CmdLoad: begin
            if (loaded < MaxIntervals) begin
              intervals[loaded] = '{interval_start_i, interval_stop_i,
                                    red_in_i, green_in_i, blue_in_i};
              loaded++;
            end
          end
          CmdRow:     lay_out_row();
          CmdRestart: restart_lanes();
          default: ;
        endcase
      end
    end
    pending_o = lane_colours_q.size();
  end

endmodule

@@ tb/interval_lane_layout_top_test.sv @@
// ============================================================================
// interval_lane_layout_top_test: stimulus and verdict for the lane layout
// Drives directed overflow and ageing cases, randomised sessions of ascending
// intervals followed by rows, then wrap cases.
// The checker beside the block predicts and compares every lane result.
// ============================================================================
module interval_lane_layout_top_test;
  import ill_pkg::*;

  localparam logic CfgViewStart = 1'b0;
  localparam logic CfgLineWidth = 1'b1;
  localparam int   CycleLimit   = 1000000;
  localparam int   RandomItems  = 230;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic        cfg_idx_i = 0;
  logic [31:0] cfg_data_i = '0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  command_i = CmdNone;
  logic [31:0] interval_start_i = '0;
  logic [31:0] interval_stop_i = '0;
  logic [7:0]  red_in_i = '0;
  logic [7:0]  green_in_i = '0;
  logic [7:0]  blue_in_i = '0;
  logic        valid_o;
  logic [3:0]  lane_index_o;
  logic [7:0]  red_out_o, green_out_o, blue_out_o;
  logic        occupied_o, overflow_o, last_lane_o;
  int          fail_count, pending;
  int          cycles = 0;
  int          issued = 0;
  bit          no_gaps = 0;

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  interval_lane_layout_top dut (.*);
  interval_lane_layout_checker u_checker (
    .*, .fail_count_o(fail_count), .pending_o(pending));

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // one request: optional gap, then hold until accepted
  task automatic send(cmd_e cmd, logic [31:0] s = '0, logic [31:0] e = '0,
                      logic [7:0] r = '0, logic [7:0] g = '0, logic [7:0] b = '0);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk_i);
    end
    start            <= 1;
    command_i        <= cmd;
    interval_start_i <= s;
    interval_stop_i  <= e;
    red_in_i         <= r;
    green_in_i       <= g;
    blue_in_i        <= b;
    do @(posedge clk_i); while (busy);
    issued++;
    if (issued % 20 == 0) no_gaps = ($urandom_range(0, 3) == 0);
  endtask

  task automatic load_random(logic [31:0] s, logic [31:0] e);
    send(CmdLoad, s, e, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    start <= 0;
    do @(posedge clk_i); while (pending != 0 || busy);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    drain();
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  initial begin
    logic [31:0] base, s, e, hi, width;
    int          n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: empty-table row, unused command, overflow, ageing, grey colour
    send(CmdRow);
    send(CmdNone);
    write_reg(CfgLineWidth, 32'd100);
    send(CmdRestart);
    send(CmdLoad, 0, 5, GreyLevel, GreyLevel, GreyLevel);
    for (int i = 1; i < 19; i++) load_random(i, 1000);
    repeat (4) send(CmdRow);

    // random sessions of ascending intervals
    base = 2000;
    while (issued < RandomItems) begin
      width = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2000) : $urandom_range(1, 64);
      write_reg(CfgViewStart, base);
      write_reg(CfgLineWidth, {16'($urandom_range(0, 16'hffff)), width[15:0]});
      send(CmdRestart);
      n  = $urandom_range(3, 20);
      s  = base;
      hi = base;
      for (int i = 0; i < n; i++) begin
        s += $urandom_range(0, 40);
        e  = s + $urandom_range(0, 200);
        if (e > hi) hi = e;
        load_random(s, e);
        if ($urandom_range(0, 9) == 0) send(CmdNone);
      end
      send(CmdRestart);
      for (int r = 0; r < 12; r++) begin
        send(CmdRow);
        if ($urandom_range(0, 15) == 0) send(CmdRestart);
        if (base + (r - 1) * width > hi) break;
      end
      base = hi + $urandom_range(1000, 32'h0800_0000);
    end

    // row end beyond 32 bits, then wrap of the row position
    write_reg(CfgViewStart, 32'hffff_ff00);
    write_reg(CfgLineWidth, 32'h0000_ffff);
    send(CmdRestart);
    load_random(32'hffff_ff80, 32'hffff_ffff);
    repeat (3) send(CmdRow);
    // zero width: single coordinate, no advance
    write_reg(CfgLineWidth, 32'hffff_0000);
    send(CmdRestart);
    repeat (2) send(CmdRow);

    drain();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
